@@ rtl/core/bdq_pkg.sv @@
// Package with shared codes, types and constants for the bounded deque with search.
package bdq_pkg;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_FIND       = 3'd4,
        CMD_READ_AT    = 3'd5,
        CMD_DELETE_AT  = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_RANGE    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROT,
        OP_SHR,
        OP_DEL,
        OP_WR
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [DATA_W-1:0]   data;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

endpackage

@@ rtl/core/bdq_if.sv @@
// Request and response channel interfaces of the bounded deque with search.
interface bdq_req_if;
    logic                valid;
    logic                ready;
    logic [2:0]          cmd;
    logic signed [31:0]  value;
    logic [5:0]          position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface bdq_rsp_if;
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic signed [31:0]  read_value;
    logic [5:0]          found_position;
    logic [6:0]          entry_count;
    logic signed [31:0]  front_value;
    logic signed [31:0]  back_value;

    modport source (output valid, output status, output read_value, output found_position,
                    output entry_count, output front_value, output back_value, input ready);
    modport sink   (input valid, input status, input read_value, input found_position,
                    input entry_count, input front_value, input back_value, output ready);
endinterface

@@ rtl/core/bdq_cell.sv @@
// One storage cell of the deque chain, holding a single entry.
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int SEL_W = 7
)
(
    input  logic                      clk,
    input  cell_ctl_t                 ctl,
    input  logic [SEL_W-1:0]          sel,
    input  logic signed [DATA_W-1:0]  left_data,
    input  logic signed [DATA_W-1:0]  right_data,
    output logic signed [DATA_W-1:0]  data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        unique case (ctl.op)
            OP_HOLD: data_next = data_reg;
            OP_ROT:  data_next = right_data;
            OP_SHR:  data_next = left_data;
            OP_DEL:  data_next = (SEL_W'(IDX) >= sel) ? right_data : data_reg;
            OP_WR:   data_next = (SEL_W'(IDX) == sel) ? ctl.data : data_reg;
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ rtl/core/bdq_cell_row.sv @@
// Ring of deque cells; cell 0 holds the front entry.
module bdq_cell_row
    import bdq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int SEL_W    = 7
)
(
    input  logic                      clk,
    input  cell_ctl_t                 ctl,
    input  logic [SEL_W-1:0]          sel,
    output logic signed [DATA_W-1:0]  head_data
);

    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_data;

        if (i == 0)
        begin : g_first
            assign left_data = ctl.data;
        end
        else
        begin : g_rest
            assign left_data = cell_data[i-1];
        end

        bdq_cell #(
            .IDX   (i),
            .SEL_W (SEL_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .sel        (sel),
            .left_data  (left_data),
            .right_data (cell_data[(i + 1) % CAPACITY]),
            .data       (cell_data[i])
        );
    end

    assign head_data = cell_data[0];

endmodule

@@ rtl/core/bounded_deque_with_search_unit.sv @@
// Top level of the bounded deque with search: command decode, ring scan and response register.
//
// The transfer edge of a command applies any change to the chain of cells (push front, pop
// front and delete at shift cells at once, push back writes one cell, pop back and clear change
// only the count). The ring then rotates through all CAPACITY cells so that every entry passes
// cell 0, where find, read at, and the front and back values are picked up. The finish state
// then loads the response register, once any earlier response has been taken. No new command
// is taken until then. A new request is taken once the previous response is in the output
// register, while that response still waits to be taken.
module bounded_deque_with_search_unit
    import bdq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    bdq_req_if.sink      req,
    bdq_rsp_if.source    rsp
);

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [IW-1:0]             k_reg;
    logic [IW-1:0]             k_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;

    cmd_t                      cmd_reg;
    logic signed [DATA_W-1:0]  value_reg;
    logic [POS_W-1:0]          pos_reg;
    status_t                   status_reg;
    logic signed [DATA_W-1:0]  rd_reg;
    logic [IW-1:0]             fp_reg;
    logic signed [DATA_W-1:0]  front_reg;
    logic signed [DATA_W-1:0]  back_reg;

    status_t                   out_status_reg;
    logic signed [DATA_W-1:0]  out_rd_reg;
    logic [IW-1:0]             out_fp_reg;
    logic [CW-1:0]             out_count_reg;
    logic signed [DATA_W-1:0]  out_front_reg;
    logic signed [DATA_W-1:0]  out_back_reg;

    logic                      accept;
    logic                      load_out;
    logic                      last_k;
    cmd_t                      req_cmd;
    status_t                   acc_status;
    logic [CW-1:0]             acc_count;
    cell_op_t                  acc_op;
    logic [CW-1:0]             acc_sel;
    logic [CMP_W-1:0]          count_ext;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          k_ext;
    logic                      list_empty;
    logic                      list_full;
    logic                      pos_bad;
    logic                      in_list;
    cell_ctl_t                 ctl;
    logic signed [DATA_W-1:0]  head_data;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign req_cmd   = cmd_t'(req.cmd);
    assign last_k    = (k_reg == IW'(CAPACITY - 1));
    assign load_out  = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp.ready);

    assign count_ext  = CMP_W'(count_reg);
    assign pos_ext    = CMP_W'(req.position);
    assign k_ext      = CMP_W'(k_reg);
    assign list_empty = (count_reg == '0);
    assign list_full  = (count_reg == CW'(CAPACITY));
    assign pos_bad    = (pos_ext >= count_ext);
    assign in_list    = (k_ext < count_ext);

    always_comb
    begin
        acc_status = STAT_OK;
        acc_count  = count_reg;
        acc_op     = OP_HOLD;
        acc_sel    = count_reg;
        unique case (req_cmd)
            CMD_PUSH_BACK:
            begin
                if (list_full)
                begin
                    acc_status = STAT_FULL;
                end
                else
                begin
                    acc_op    = OP_WR;
                    acc_count = count_reg + CW'(1);
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (list_full)
                begin
                    acc_status = STAT_FULL;
                end
                else
                begin
                    acc_op    = OP_SHR;
                    acc_count = count_reg + CW'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (list_empty)
                begin
                    acc_status = STAT_EMPTY;
                end
                else
                begin
                    acc_count = count_reg - CW'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (list_empty)
                begin
                    acc_status = STAT_EMPTY;
                end
                else
                begin
                    acc_op    = OP_DEL;
                    acc_sel   = '0;
                    acc_count = count_reg - CW'(1);
                end
            end
            CMD_FIND:
            begin
                acc_status = STAT_NOTFOUND;
            end
            CMD_READ_AT:
            begin
                if (list_empty)
                begin
                    acc_status = STAT_EMPTY;
                end
                else if (pos_bad)
                begin
                    acc_status = STAT_RANGE;
                end
            end
            CMD_DELETE_AT:
            begin
                if (list_empty)
                begin
                    acc_status = STAT_EMPTY;
                end
                else if (pos_bad)
                begin
                    acc_status = STAT_RANGE;
                end
                else
                begin
                    acc_op    = OP_DEL;
                    acc_sel   = CW'(req.position);
                    acc_count = count_reg - CW'(1);
                end
            end
            CMD_CLEAR:
            begin
                acc_count = '0;
            end
            default:
            begin
                acc_status = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        ctl.data = req.value;
        if (state_reg == S_SCAN)
        begin
            ctl.op = OP_ROT;
        end
        else if (accept)
        begin
            ctl.op = acc_op;
        end
        else
        begin
            ctl.op = OP_HOLD;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    count_next = acc_count;
                    k_next     = '0;
                end
            end
            S_SCAN:
            begin
                if (last_k)
                begin
                    state_next = S_FINISH;
                    k_next     = '0;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            S_FINISH:
            begin
                if (load_out)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req_cmd;
            value_reg  <= req.value;
            pos_reg    <= req.position;
            status_reg <= acc_status;
            rd_reg     <= '0;
            fp_reg     <= '0;
            front_reg  <= '0;
            back_reg   <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            if (cmd_reg == CMD_FIND && status_reg == STAT_NOTFOUND && in_list
                && head_data == value_reg)
            begin
                status_reg <= STAT_OK;
                fp_reg     <= k_reg;
            end
            if (cmd_reg == CMD_READ_AT && status_reg == STAT_OK
                && k_ext == CMP_W'(pos_reg))
            begin
                rd_reg <= head_data;
            end
            if (count_reg != '0 && k_reg == '0)
            begin
                front_reg <= head_data;
            end
            if (count_reg != '0 && k_ext + CMP_W'(1) == count_ext)
            begin
                back_reg <= head_data;
            end
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_rd_reg     <= rd_reg;
            out_fp_reg     <= fp_reg;
            out_count_reg  <= count_reg;
            out_front_reg  <= front_reg;
            out_back_reg   <= back_reg;
        end
    end

    bdq_cell_row #(
        .CAPACITY (CAPACITY),
        .SEL_W    (CW)
    ) u_row (
        .clk       (clk),
        .ctl       (ctl),
        .sel       (accept ? acc_sel : count_reg),
        .head_data (head_data)
    );

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.read_value     = out_rd_reg;
    assign rsp.found_position = POS_W'(out_fp_reg);
    assign rsp.entry_count    = CNT_W'(out_count_reg);
    assign rsp.front_value    = out_front_reg;
    assign rsp.back_value     = out_back_reg;

endmodule

@@ rtl/core/bdq_checker.sv @@
// Port-level checker for the bounded deque with search, bound to the top level.
module bdq_checker
    import bdq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rsp_valid,
    input  logic                      rsp_ready,
    input  logic [STAT_W-1:0]         status,
    input  logic signed [DATA_W-1:0]  read_value,
    input  logic [POS_W-1:0]          found_position,
    input  logic [CNT_W-1:0]          entry_count,
    input  logic signed [DATA_W-1:0]  front_value,
    input  logic signed [DATA_W-1:0]  back_value
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_count)
            && $stable(front_value) && $stable(back_value))
        else $error("response changed while stalled");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_EMPTY |-> entry_count == '0)
        else $error("empty status with entries held");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && entry_count == '0 |-> front_value == '0 && back_value == '0)
        else $error("front or back nonzero on empty list");

    a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_RANGE |-> entry_count != '0 && read_value == '0
            && found_position == '0)
        else $error("range status on empty list or with data");

endmodule

bind bounded_deque_with_search_unit bdq_checker u_bdq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .read_value     (rsp.read_value),
    .found_position (rsp.found_position),
    .entry_count    (rsp.entry_count),
    .front_value    (rsp.front_value),
    .back_value     (rsp.back_value)
);
